// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files; only m3inv_queue includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/m3inv_pkg.sv =====
`default_nettype none
package m3inv_pkg;

  localparam int COF_W  = 33;  // transposed cofactor, signed Q17.16
  localparam int DET_W  = 49;  // determinant, signed Q25.24
  localparam int DEN_W  = 48;  // determinant magnitude
  localparam int NUM_W  = 56;  // scaled cofactor magnitude
  localparam int QUO_W  = 33;  // quotient bits worked out by the divider
  localparam int THR_W  = 32;

  localparam logic [31:0] Q16_ONE = 32'h0001_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] e00;
    logic signed [15:0] e01;
    logic signed [15:0] e02;
    logic signed [15:0] e10;
    logic signed [15:0] e11;
    logic signed [15:0] e12;
    logic signed [15:0] e20;
    logic signed [15:0] e21;
    logic signed [15:0] e22;
  } item_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               singular;
    logic signed [63:0] determinant;
  } result_t;

  // classified matrix handed from the front part to the divider
  typedef struct packed {
    logic [8:0][COF_W-1:0] cof;
    logic [DET_W-1:0]      det;
    logic                  singular;
  } work_t;

endpackage
`default_nettype wire

// ===== sv/m3inv_front.sv =====
`default_nettype none
module m3inv_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire m3inv_pkg::item_t                item,
  input  wire logic [m3inv_pkg::THR_W-1:0]     threshold,
  input  wire logic                            queue_full,
  output logic                                 push,
  output m3inv_pkg::work_t                     work
);

  localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  logic signed [15:0] a [9];
  logic signed [31:0] prod [18];
  logic signed [15:0] a1_row [3];
  logic               f1_valid;
  logic signed [m3inv_pkg::COF_W-1:0] cof2 [9];
  logic signed [15:0] a2_row [3];
  logic               f2_valid;
  logic signed [m3inv_pkg::COF_W-1:0] cof3 [9];
  logic signed [m3inv_pkg::DET_W-1:0] term [3];
  logic               f3_valid;
  logic               f4_valid;
  logic signed [m3inv_pkg::DET_W-1:0] det_sum;
  logic [m3inv_pkg::DET_W-1:0]        det_mag;
  logic               adv;

  assign a[0] = item.e00;
  assign a[1] = item.e01;
  assign a[2] = item.e02;
  assign a[3] = item.e10;
  assign a[4] = item.e11;
  assign a[5] = item.e12;
  assign a[6] = item.e20;
  assign a[7] = item.e21;
  assign a[8] = item.e22;

  // advance the whole front when its last stage is empty or moves into the queue
  assign adv        = !f4_valid || !queue_full;
  assign item_ready = adv;
  assign push       = f4_valid && !queue_full;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= item_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
    end
  end

  // element products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 18; j++) begin
        prod[j] <= a[PA[j]] * a[PB[j]];
      end
      for (int j = 0; j < 3; j++) begin
        a1_row[j] <= a[j];
      end
    end
  end

  // transposed cofactors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        cof2[j] <= $signed({prod[2*j][31], prod[2*j]})
                 - $signed({prod[2*j+1][31], prod[2*j+1]});
      end
      a2_row <= a1_row;
    end
  end

  // first-row expansion terms
  always_ff @(posedge clk) begin
    if (adv) begin
      term[0] <= m3inv_pkg::DET_W'(a2_row[0]) * m3inv_pkg::DET_W'(cof2[0]);
      term[1] <= m3inv_pkg::DET_W'(a2_row[1]) * m3inv_pkg::DET_W'(cof2[3]);
      term[2] <= m3inv_pkg::DET_W'(a2_row[2]) * m3inv_pkg::DET_W'(cof2[6]);
      cof3    <= cof2;
    end
  end

  assign det_sum = term[0] + term[1] + term[2];
  assign det_mag = det_sum[m3inv_pkg::DET_W-1] ? m3inv_pkg::DET_W'(-det_sum)
                                               : m3inv_pkg::DET_W'(det_sum);

  // determinant and singular classification
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        work.cof[j] <= cof3[j];
      end
      work.det      <= det_sum;
      work.singular <= (det_sum == '0) ||
                       (det_mag < m3inv_pkg::DET_W'(threshold));
    end
  end

endmodule
`default_nettype wire

// ===== sv/m3inv_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module m3inv_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire m3inv_pkg::work_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output m3inv_pkg::work_t       head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);

  m3inv_pkg::work_t slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = slot[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, count != DEPTH_C)
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, count != '0)
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == CW'($past(count) + 1'b1))

endmodule
`default_nettype wire

// ===== sv/m3inv_back.sv =====
`default_nettype none
module m3inv_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire m3inv_pkg::work_t  head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output m3inv_pkg::result_t     result
);

  localparam int STEPS = m3inv_pkg::QUO_W;
  localparam int NW    = m3inv_pkg::NUM_W;
  localparam int DW    = m3inv_pkg::DEN_W;
  localparam int BW    = DW + STEPS;

  typedef struct packed {
    logic [NW-1:0]                 rem;
    logic [m3inv_pkg::QUO_W-1:0]   quo;
    logic                          neg;
    logic                          ovf;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]                   lane;
    logic [DW-1:0]                 den;
    logic [m3inv_pkg::DET_W-1:0]   det;
    logic                          singular;
  } stage_t;

  stage_t         st [STEPS+1];
  logic [STEPS:0] vld;
  logic           adv;
  logic [31:0]    elem [9];
  logic [m3inv_pkg::DET_W-1:0] det_mag;

  // move the whole divider when the output register is free or being taken
  assign adv = !result_valid || result_ready;
  assign pop = adv && head_valid;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[STEPS-1:0], head_valid};
      result_valid <= vld[STEPS];
    end
  end

  assign det_mag = head.det[m3inv_pkg::DET_W-1] ? m3inv_pkg::DET_W'(-$signed(head.det))
                                                : head.det;

  // set up magnitudes, signs and the early overflow check
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        logic [m3inv_pkg::COF_W-1:0] cm;
        cm = head.cof[j][m3inv_pkg::COF_W-1] ? m3inv_pkg::COF_W'(-$signed(head.cof[j]))
                                             : head.cof[j];
        st[0].lane[j].rem <= {cm[31:0], 24'b0};
        st[0].lane[j].quo <= '0;
        st[0].lane[j].neg <= head.cof[j][m3inv_pkg::COF_W-1]
                           ^ head.det[m3inv_pkg::DET_W-1];
        st[0].lane[j].ovf <= (DW'(cm[31:STEPS-24]) >= det_mag[DW-1:0]);
      end
      st[0].den      <= det_mag[DW-1:0];
      st[0].det      <= head.det;
      st[0].singular <= head.singular;
    end
  end

  // one restoring quotient bit per stage, most significant first
  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    localparam int K = STEPS - s;
    logic [BW-1:0] big;
    stage_t        st_next;
    assign big = BW'(st[s-1].den) << K;
    // subtract the shifted divisor from each lane where it fits
    always_comb begin
      st_next = st[s-1];
      for (int j = 0; j < 9; j++) begin
        if (BW'(st[s-1].lane[j].rem) >= big) begin
          st_next.lane[j].rem    = st[s-1].lane[j].rem - big[NW-1:0];
          st_next.lane[j].quo[K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[s] <= st_next;
      end
    end
  end

  // saturate and sign the quotients, or substitute the identity
  always_comb begin
    for (int j = 0; j < 9; j++) begin
      lane_t ln;
      ln = st[STEPS].lane[j];
      if (st[STEPS].singular) begin
        elem[j] = (j % 4 == 0) ? m3inv_pkg::Q16_ONE : '0;
      end else if (ln.neg) begin
        elem[j] = (ln.ovf || ln.quo > m3inv_pkg::QUO_W'(m3inv_pkg::NEG_MAX))
                ? m3inv_pkg::NEG_MAX : 32'(-ln.quo[31:0]);
      end else begin
        elem[j] = (ln.ovf || ln.quo > m3inv_pkg::QUO_W'(m3inv_pkg::POS_MAX))
                ? m3inv_pkg::POS_MAX : ln.quo[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      result.inv00       <= elem[0];
      result.inv01       <= elem[1];
      result.inv02       <= elem[2];
      result.inv10       <= elem[3];
      result.inv11       <= elem[4];
      result.inv12       <= elem[5];
      result.inv20       <= elem[6];
      result.inv21       <= elem[7];
      result.inv22       <= elem[8];
      result.singular    <= st[STEPS].singular;
      result.determinant <= 64'($signed(st[STEPS].det));
    end
  end

endmodule
`default_nettype wire

// ===== sv/matrix3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, signed Q8.8 in, signed Q16.16 out.
// Input channel item_valid / item_ready / item carries one matrix per transfer;
// result channel result_valid / result_ready / result returns one inverse,
// the singular flag and the Q40.24 determinant for every matrix, in order.
// cfg_valid / cfg_ready / cfg_data writes the threshold register (always ready);
// write it only while no matrix is in flight.
// Throughput: one matrix per cycle unless result_ready holds the divider.
// Path from input transfer to result valid: four front stages (products,
// cofactors, determinant terms, determinant and classification), the
// queue, a setup stage, 33 divider stages of one quotient bit each and
// the output register; the nine-lane restoring divider sets the latency.
// Reset clears all valid bits and the queue and sets the threshold to 1.
// When the receiver stalls, the divider holds; the front keeps taking items
// until the queue fills, then item_ready drops.
`default_nettype none
module matrix3_inverse #(
  parameter int QUEUE_DEPTH = 2  // 2 or more
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire m3inv_pkg::item_t            item,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output m3inv_pkg::result_t               result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [m3inv_pkg::THR_W-1:0] cfg_data
);

  logic [m3inv_pkg::THR_W-1:0] threshold;
  logic             queue_full;
  logic             push;
  logic             pop;
  logic             head_valid;
  m3inv_pkg::work_t work;
  m3inv_pkg::work_t head;

  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= m3inv_pkg::THR_W'(1);
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  m3inv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .threshold  (threshold),
    .queue_full (queue_full),
    .push       (push),
    .work       (work)
  );

  m3inv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (work),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  m3inv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
